/* hw/rtl/akx_pkg.sv */
// shared types and constants for the autokey xor byte cipher
`timescale 1ns / 1ps
`default_nettype none

package akx_pkg;

    // widths of the data path and of the configuration port
    localparam int unsigned KEY_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_START_KEY    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_MULT_KEY     = t_cfg_idx'(1);
    localparam t_cfg_idx REG_ADD_KEY      = t_cfg_idx'(2);
    localparam t_cfg_idx REG_DECRYPT_MODE = t_cfg_idx'(3);

    // reset values of the configuration registers
    localparam logic [KEY_W-1:0] START_KEY_RST = '0;
    localparam logic [KEY_W-1:0] MULT_KEY_RST  = KEY_W'(1);
    localparam logic [KEY_W-1:0] ADD_KEY_RST   = '0;

    // register set as seen by the key unit
    typedef struct packed {
        logic [KEY_W-1:0] start_key;
        logic [KEY_W-1:0] mult_key;
        logic [KEY_W-1:0] add_key;
        logic             decrypt_mode;
    } t_cfg;

endpackage

`default_nettype wire

/* hw/rtl/akx_cfg_regs.sv */
// configuration register set of the autokey xor byte cipher
`timescale 1ns / 1ps
`default_nettype none

module akx_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [akx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [akx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output akx_pkg::t_cfg                       o_cfg
);
    import akx_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // decode one write beat, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_KEY:    n_cfg.start_key    = i_cfg_data[KEY_W-1:0];
                REG_MULT_KEY:     n_cfg.mult_key     = i_cfg_data[KEY_W-1:0];
                REG_ADD_KEY:      n_cfg.add_key      = i_cfg_data[KEY_W-1:0];
                REG_DECRYPT_MODE: n_cfg.decrypt_mode = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_key    <= START_KEY_RST;
            r_cfg.mult_key     <= MULT_KEY_RST;
            r_cfg.add_key      <= ADD_KEY_RST;
            r_cfg.decrypt_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/akx_key_unit.sv */
// running key register with the xor and the multiply-add key update
`timescale 1ns / 1ps
`default_nettype none

module akx_key_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [akx_pkg::BYTE_W-1:0] i_data,
    input  wire logic                       i_first,
    input  wire akx_pkg::t_cfg              i_cfg,
    output logic [akx_pkg::BYTE_W-1:0]      o_byte
);
    import akx_pkg::*;

    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   n_key;
    logic [KEY_W-1:0]   key;
    logic [BYTE_W-1:0]  fb;
    logic [KEY_W-1:0]   sum;
    logic [2*KEY_W-1:0] prod;

    // a first mark reloads the key before the byte is used
    assign key    = i_first ? i_cfg.start_key : r_key;
    assign o_byte = i_data ^ key[KEY_W-1:KEY_W-BYTE_W];

    // ciphertext feedback: output when encrypting, input when decrypting
    assign fb   = i_cfg.decrypt_mode ? i_data : o_byte;
    assign sum  = KEY_W'({{(KEY_W-BYTE_W){1'b0}}, fb}) + key;
    assign prod = sum * i_cfg.mult_key;
    assign n_key = prod[KEY_W-1:0] + i_cfg.add_key;

    // key advances once per byte that leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_step) begin
            r_key <= n_key;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/autokey_xor_byte_cipher_core.sv */
// top level of the autokey xor byte cipher
//
//  channel  direction  handshake               payload
//  input    in         i_valid / o_ready       i_data_byte, i_first_byte, i_last_byte
//  output   out        o_valid / i_ready       o_out_byte, o_out_last
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle sustained without output stall; a byte passes the input and
// result registers, the key loop (add, 16x16 multiply, add) is combinational
// reset is synchronous and empties both stages and restores the register values
// an output stall holds the output register; the input register still takes one
// more beat, and ready drops only when both stages are full
`timescale 1ns / 1ps
`default_nettype none

module autokey_xor_byte_cipher_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [akx_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                           i_first_byte,
    input  wire logic                           i_last_byte,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [akx_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                o_out_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [akx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [akx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import akx_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_first;
    logic              r_in_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic [BYTE_W-1:0] res_byte;
    logic              move;
    logic              take;

    // register set
    akx_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // stage handshakes
    assign move    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || move;
    assign take    = i_valid && o_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
    end

    // xor and key update
    akx_key_unit u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (move),
        .i_data  (r_in_data),
        .i_first (r_in_first),
        .i_cfg   (cfg),
        .o_byte  (res_byte)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte <= res_byte;
            r_out_last <= r_in_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

endmodule

`default_nettype wire

/* hw/rtl/akx_checker.sv */
// port-level checks of the cipher core and their binding
`timescale 1ns / 1ps
`default_nettype none

module akx_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       o_ready,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic [akx_pkg::BYTE_W-1:0] o_out_byte,
    input  wire logic                       o_out_last
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_byte) && $stable(o_out_last)))
        else $error("result beat changed while stalled");

    // input backpressure only when the result side is stalled
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input ready low without output stall");

    // after an accepted byte the result side shows a valid beat, though not always its own
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##2 o_valid)
        else $error("no result two cycles after input beat");

    // reset empties the result stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind autokey_xor_byte_cipher_core akx_checker u_akx_checker (.*);

`default_nettype wire

/* verif/autokey_xor_byte_cipher_core_tb.sv */
// self-checking testbench for the autokey xor byte cipher core
`timescale 1ns / 1ps

module testbench;

    import akx_pkg::*;

    // one input beat and one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } t_byte_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } t_cipher_out;

    // pacing styles for either side
    typedef enum int unsigned {
        PACE_NONE,
        PACE_FULL,
        PACE_SPARSE
    } t_pace;

    localparam t_cfg_idx    REG_UNUSED_LO  = REG_DECRYPT_MODE + t_cfg_idx'(1);
    localparam t_cfg_idx    REG_UNUSED_HI  = '1;
    localparam int unsigned LONG_HOLD      = 64;
    localparam int unsigned QUIET_LIMIT    = 1000;
    localparam int unsigned RANDOM_PHASES  = 10;
    localparam int unsigned PHASE_BEATS    = 100;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_PRINTED    = 30;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  o_ready;
    logic [BYTE_W-1:0]     in_data     = '0;
    logic                  in_first    = 1'b0;
    logic                  in_last     = 1'b0;
    logic                  o_valid;
    logic                  out_ready   = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_out_last;
    logic                  cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // predictor state: register copy and running key
    t_cfg              cfg_shadow;
    logic [KEY_W-1:0]  key_shadow;

    t_byte_beat        pending_bytes[$];
    t_cipher_out       expected_bytes[$];

    t_pace             tx_pace        = PACE_NONE;
    t_pace             rx_pace        = PACE_NONE;
    int unsigned       send_gap       = 0;
    int unsigned       recv_wait      = 0;
    int unsigned       hold_left      = 0;
    int unsigned       stall_requests = 0;
    int unsigned       stall_served   = 0;
    int unsigned       msg_left       = 0;
    int unsigned       error_count    = 0;

    autokey_xor_byte_cipher_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_ready      (o_ready),
        .i_data_byte  (in_data),
        .i_first_byte (in_first),
        .i_last_byte  (in_last),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned draw_idle(input t_pace pace);
        case (pace)
            PACE_FULL:   return $urandom_range(0, 5);
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            default:     return 0;
        endcase
    endfunction

    // xor with the high key byte, then fold the ciphertext byte into the key
    function automatic t_cipher_out cipher_byte(input t_byte_beat beat);
        t_cipher_out      res;
        logic [KEY_W-1:0] key;
        logic [BYTE_W-1:0] feedback;
        if (beat.first)
            key_shadow = cfg_shadow.start_key;
        key = key_shadow;
        res.out_byte = beat.data ^ key[KEY_W-1:BYTE_W];
        res.out_last = beat.last;
        feedback = cfg_shadow.decrypt_mode ? beat.data : res.out_byte;
        key_shadow = (KEY_W'(feedback) + key) * cfg_shadow.mult_key + cfg_shadow.add_key;
        return res;
    endfunction

    // one register write beat, shadow updated on acceptance
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_KEY:    cfg_shadow.start_key    = val;
            REG_MULT_KEY:     cfg_shadow.mult_key     = val;
            REG_ADD_KEY:      cfg_shadow.add_key      = val;
            REG_DECRYPT_MODE: cfg_shadow.decrypt_mode = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic first,
                             input logic last);
        pending_bytes.push_back('{data: data, first: first, last: last});
    endtask

    // mostly framed messages that may span phases, some with random marks
    task automatic push_random_byte();
        t_byte_beat beat;
        beat.data = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            beat.first = 1'($urandom_range(0, 1));
            beat.last  = 1'($urandom_range(0, 1));
        end else begin
            beat.first = (msg_left == 0);
            if (msg_left == 0)
                msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                       : $urandom_range(1, 16);
            beat.last = (msg_left == 1);
            msg_left--;
        end
        pending_bytes.push_back(beat);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return KEY_W'(1);
            3:       return KEY_W'(16'h8000);
            default: return KEY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_bytes
        t_byte_beat nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && o_ready)
                expected_bytes.push_back(cipher_byte('{data: in_data, first: in_first,
                                                       last: in_last}));
            if (!in_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    in_data  <= nxt.data;
                    in_first <= nxt.first;
                    in_last  <= nxt.last;
                    in_valid <= 1'b1;
                    send_gap <= draw_idle(tx_pace);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver pacing
    always @(posedge i_clk) begin : watch_results
        t_cipher_out want;
        int unsigned wait_n;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
        end else begin
            wait_n = recv_wait;
            if (o_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("result beat %02h/%0b with nothing pending",
                                           o_out_byte, o_out_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.out_byte)
                        report_error($sformatf("out_byte %02h, expected %02h",
                                               o_out_byte, want.out_byte));
                    if (o_out_last !== want.out_last)
                        report_error($sformatf("out_last %0b, expected %0b",
                                               o_out_last, want.out_last));
                end
                wait_n = draw_idle(rx_pace);
            end
            recv_wait <= (wait_n != 0) ? wait_n - 1 : 0;
            if (stall_requests != stall_served) begin
                stall_served <= stall_served + 1;
                hold_left    <= LONG_HOLD;
                out_ready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (wait_n == 0);
            end
        end
    end

    // give up after a long stretch with no beat moving
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && o_ready) || (o_valid && out_ready)
                    || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("** autokey_xor_byte_cipher_core: FAILED **");
        $finish;
    end

    // stimulus sequence
    initial begin : stimulus
        cfg_shadow.start_key    = START_KEY_RST;
        cfg_shadow.mult_key     = MULT_KEY_RST;
        cfg_shadow.add_key      = ADD_KEY_RST;
        cfg_shadow.decrypt_mode = 1'b0;
        key_shadow              = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers, no first mark yet so the key starts at zero
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b1);
        // key carries on past a last mark
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
        wait_drained();

        // all-ones keys in decrypt mode, plus writes to unused indexes
        write_reg(REG_START_KEY, '1);
        write_reg(REG_MULT_KEY, '1);
        write_reg(REG_ADD_KEY, '1);
        write_reg(REG_DECRYPT_MODE, 16'h0001);
        write_reg(REG_UNUSED_LO, 16'h1234);
        write_reg(REG_UNUSED_HI, '1);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b1);
        wait_drained();

        // zero keys; a wide value leaves decrypt mode cleared
        write_reg(REG_DECRYPT_MODE, 16'hFFFE);
        write_reg(REG_START_KEY, '0);
        write_reg(REG_MULT_KEY, '0);
        write_reg(REG_ADD_KEY, '0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'hFE, 1'b0, 1'b1);
        wait_drained();

        // random phases, messages may run across a register change
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(REG_START_KEY, pick_key());
            write_reg(REG_MULT_KEY, pick_key());
            write_reg(REG_ADD_KEY, pick_key());
            write_reg(REG_DECRYPT_MODE, CFG_DATA_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED_LO + t_cfg_idx'($urandom_range(0, 251)),
                          CFG_DATA_W'($urandom_range(0, 65535)));
            if (p == 1) begin
                tx_pace = PACE_NONE;
                rx_pace = PACE_NONE;
            end else begin
                tx_pace = t_pace'($urandom_range(0, 2));
                rx_pace = t_pace'($urandom_range(0, 2));
            end
            for (int n = 0; n < PHASE_BEATS; n++)
                push_random_byte();
            if (p == 2 || $urandom_range(0, 2) == 0)
                stall_requests++;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_bytes.size()));
        if (error_count == 0)
            $display("** autokey_xor_byte_cipher_core: PASSED **");
        else
            $display("** autokey_xor_byte_cipher_core: FAILED **");
        $finish;
    end

endmodule
